// ===== rtl/core/hht_pkg.sv =====
// hht_pkg: types, codes and sizes shared by the heartbeat health table
// used by hht_ram users, heartbeat_health_table_top and hht_checker
package hht_pkg;

   localparam int SLOT_COUNT_DEF = 64;

   localparam int KEY_W  = 32;
   localparam int TIME_W = 48;
   localparam int THR_W  = 32;
   localparam int CNT7_W = 7;

   // command codes
   localparam logic [1:0] CMD_REGISTER = 2'd0;
   localparam logic [1:0] CMD_BEAT     = 2'd1;
   localparam logic [1:0] CMD_CHECK    = 2'd2;
   localparam logic [1:0] CMD_SNAPSHOT = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EXISTS   = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

   // health levels
   localparam logic [1:0] LVL_GREEN  = 2'd0;
   localparam logic [1:0] LVL_YELLOW = 2'd1;
   localparam logic [1:0] LVL_ORANGE = 2'd2;
   localparam logic [1:0] LVL_RED    = 2'd3;

   // csr indexes
   localparam logic [1:0] CSR_YELLOW = 2'd0;
   localparam logic [1:0] CSR_ORANGE = 2'd1;
   localparam logic [1:0] CSR_RED    = 2'd2;
   localparam logic [1:0] CSR_START  = 2'd3;

   // csr reset values
   localparam logic [THR_W-1:0]  YELLOW_RST = 32'd30000;
   localparam logic [THR_W-1:0]  ORANGE_RST = 32'd60000;
   localparam logic [THR_W-1:0]  RED_RST    = 32'd120000;
   localparam logic [TIME_W-1:0] START_RST  = 48'd0;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [KEY_W-1:0]  agent_key;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [1:0]        health_level;
      logic [CNT7_W-1:0] registered_count;
      logic [CNT7_W-1:0] healthy_count;
      logic [TIME_W-1:0] up_ms;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  agent;
      logic [TIME_W-1:0] last_beat;
   } slot_entry_type;

   localparam int SLOT_W = $bits(slot_entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESP
   } hht_state_type;

endpackage

// ===== rtl/core/hht_ram.sv =====
// hht_ram: generic single-write, single-read ram with registered read
// no dependencies
module hht_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/heartbeat_health_table_top.sv =====
// heartbeat_health_table_top: agent table with heartbeat timeout grading
// depends on hht_pkg and hht_ram
//
// Each request carries a command (register, heartbeat, check, snapshot), an
// agent id and the current millisecond time, and yields exactly one response.
// The slot table (valid bit, id, last beat time) lives in one ram with a
// registered read. Every request scans all SLOT_COUNT slots in order
// through a two-stage pipe behind the ram (stage one: id compare and
// 48-bit elapsed subtract, stage two: threshold grading and accumulation),
// then the write-back state updates the slot if needed and loads the
// response register. The next request is accepted only after that; the
// scan of the slot ram, one slot per cycle, sets how long a request takes.
// The write-back state waits while an older response still sits untaken in
// the output register. A new request can be taken while the previous
// response still waits in the output register. After reset a clearing pass
// writes every slot empty, one per cycle, with req_ready held low; csr
// writes are taken at any time but are meant to happen only while the
// block is idle.
module heartbeat_health_table_top #(
   parameter int SLOT_COUNT = hht_pkg::SLOT_COUNT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  hht_pkg::req_type            req_payload,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output hht_pkg::rsp_type            rsp_payload,
   // configuration write port
   input  logic                        csr_we,
   input  logic [1:0]                  csr_addr,
   input  logic [hht_pkg::TIME_W-1:0]  csr_wdata
);

   import hht_pkg::*;

   localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(SLOT_COUNT - 1);

   // control state
   hht_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              p1_ff, p1_in;
   logic [ADDR_W-1:0] p1_idx_ff;
   logic              s2_valid_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  total_ff, total_in;

   // latched request
   logic [1:0]        cmd_ff, cmd_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [TIME_W-1:0] now_ff, now_in;

   // scan pipe stage two
   logic              s2_hit_ff, s2_hit_in;
   logic              s2_used_ff, s2_used_in;
   logic [TIME_W-1:0] s2_el_ff, s2_el_in;
   logic [ADDR_W-1:0] s2_idx_ff;

   // scan results
   logic              found_ff, found_in;
   logic [ADDR_W-1:0] found_idx_ff, found_idx_in;
   logic [1:0]        found_level_ff, found_level_in;
   logic              free_found_ff, free_found_in;
   logic [ADDR_W-1:0] free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]  healthy_ff, healthy_in;

   // thresholds and uptime origin
   logic [THR_W-1:0]  yellow_ff, yellow_in;
   logic [THR_W-1:0]  orange_ff, orange_in;
   logic [THR_W-1:0]  red_ff, red_in;
   logic [TIME_W-1:0] start_ff, start_in;

   rsp_type           rsp_payload_ff, rsp_payload_in;

   // ram ports
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   slot_entry_type    ram_wdata;
   logic [SLOT_W-1:0] ram_rdata;
   slot_entry_type    rd_entry;

   logic [1:0]        s2_level;

   hht_ram #(
      .WIDTH  (SLOT_W),
      .DEPTH  (SLOT_COUNT),
      .ADDR_W (ADDR_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cnt_ff),
      .rd_data (ram_rdata)
   );

   assign rd_entry = slot_entry_type'(ram_rdata);

   // stage one: id compare and elapsed time on the slot just read
   assign s2_hit_in  = rd_entry.valid && (rd_entry.agent == key_ff);
   assign s2_used_in = rd_entry.valid;
   assign s2_el_in   = now_ff - rd_entry.last_beat;

   // stage two: grading, tests in fixed order red, orange, yellow
   always_comb begin
      if (s2_el_ff >= TIME_W'(red_ff)) begin
         s2_level = LVL_RED;
      end else if (s2_el_ff >= TIME_W'(orange_ff)) begin
         s2_level = LVL_ORANGE;
      end else if (s2_el_ff >= TIME_W'(yellow_ff)) begin
         s2_level = LVL_YELLOW;
      end else begin
         s2_level = LVL_GREEN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      p1_in          = 1'b0;
      total_in       = total_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      now_in         = now_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_level_in = found_level_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      healthy_in     = healthy_ff;
      yellow_in      = yellow_ff;
      orange_in      = orange_ff;
      red_in         = red_ff;
      start_in       = start_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff;
      ram_we         = 1'b0;
      ram_waddr      = cnt_ff;
      ram_wdata      = '0;

      // response taken downstream
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // csr writes, unknown indexes cannot occur with a two-bit index
      if (csr_we) begin
         case (csr_addr)
            CSR_YELLOW: yellow_in = csr_wdata[THR_W-1:0];
            CSR_ORANGE: orange_in = csr_wdata[THR_W-1:0];
            CSR_RED:    red_in    = csr_wdata[THR_W-1:0];
            CSR_START:  start_in  = csr_wdata;
            default:    ;
         endcase
      end

      // accumulate scan results, slots arrive in index order
      if (s2_valid_ff) begin
         if (s2_hit_ff) begin
            found_in       = 1'b1;
            found_idx_in   = s2_idx_ff;
            found_level_in = s2_level;
         end
         if (!s2_used_ff && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = s2_idx_ff;
         end
         if (s2_used_ff && (s2_level == LVL_GREEN || s2_level == LVL_YELLOW)) begin
            healthy_in = healthy_ff + CNT_W'(1);
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            // write every slot empty
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = '0;
            cnt_in    = cnt_ff + ADDR_W'(1);
            if (cnt_ff == LAST_SLOT) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_payload.cmd;
               key_in        = req_payload.agent_key;
               now_in        = req_payload.now_ms;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               healthy_in    = '0;
               cnt_in        = '0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one slot read per cycle
            p1_in  = 1'b1;
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == LAST_SLOT) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p1_ff && !s2_valid_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // wait for a free output register, then write back and respond
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = '0;
               state_in       = ST_IDLE;
               case (cmd_ff)
                  CMD_REGISTER: begin
                     if (found_ff) begin
                        rsp_payload_in.status = STATUS_EXISTS;
                     end else if (!free_found_ff) begin
                        rsp_payload_in.status = STATUS_FULL;
                     end else begin
                        rsp_payload_in.status = STATUS_OK;
                        ram_we              = 1'b1;
                        ram_waddr           = free_idx_ff;
                        ram_wdata.valid     = 1'b1;
                        ram_wdata.agent     = key_ff;
                        ram_wdata.last_beat = now_ff;
                        total_in            = total_ff + CNT_W'(1);
                     end
                  end
                  CMD_BEAT: begin
                     if (found_ff) begin
                        rsp_payload_in.status = STATUS_OK;
                        ram_we              = 1'b1;
                        ram_waddr           = found_idx_ff;
                        ram_wdata.valid     = 1'b1;
                        ram_wdata.agent     = key_ff;
                        ram_wdata.last_beat = now_ff;
                     end else begin
                        rsp_payload_in.status = STATUS_NOTFOUND;
                     end
                  end
                  CMD_CHECK: begin
                     if (found_ff) begin
                        rsp_payload_in.status       = STATUS_OK;
                        rsp_payload_in.health_level = found_level_ff;
                     end else begin
                        rsp_payload_in.status       = STATUS_NOTFOUND;
                        rsp_payload_in.health_level = LVL_RED;
                     end
                  end
                  default: begin
                     // snapshot, counts saturate at 127
                     rsp_payload_in.status = STATUS_OK;
                     rsp_payload_in.up_ms  = now_ff - start_ff;
                     rsp_payload_in.registered_count =
                        (total_ff > CNT_W'(127)) ? 7'd127 : CNT7_W'(total_ff);
                     rsp_payload_in.healthy_count =
                        (healthy_ff > CNT_W'(127)) ? 7'd127 : CNT7_W'(healthy_ff);
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         p1_ff         <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         total_ff      <= '0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         healthy_ff    <= '0;
         yellow_ff     <= YELLOW_RST;
         orange_ff     <= ORANGE_RST;
         red_ff        <= RED_RST;
         start_ff      <= START_RST;
      end else begin
         cnt_ff        <= cnt_in;
         p1_ff         <= p1_in;
         s2_valid_ff   <= p1_ff;
         rsp_valid_ff  <= rsp_valid_in;
         total_ff      <= total_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         healthy_ff    <= healthy_in;
         yellow_ff     <= yellow_in;
         orange_ff     <= orange_in;
         red_ff        <= red_in;
         start_ff      <= start_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      p1_idx_ff      <= cnt_ff;
      s2_idx_ff      <= p1_idx_ff;
      s2_hit_ff      <= s2_hit_in;
      s2_used_ff     <= s2_used_in;
      s2_el_ff       <= s2_el_in;
      cmd_ff         <= cmd_in;
      key_ff         <= key_in;
      now_ff         <= now_in;
      found_idx_ff   <= found_idx_in;
      found_level_ff <= found_level_in;
      free_idx_ff    <= free_idx_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== rtl/core/hht_checker.sv =====
// hht_checker: port-level assertions for the heartbeat health table
// depends on hht_pkg, bound to heartbeat_health_table_top
module hht_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input hht_pkg::rsp_type rsp_payload
);

   import hht_pkg::*;

   // response held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   // clearing pass follows reset, no request taken right away
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready during clearing pass");

   // one request at a time, the scan starts after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted during scan");

   // healthy agents are a subset of registered ones
   a_healthy_le_reg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.healthy_count <= rsp_payload.registered_count)
      else $error("healthy count above registered count");

   // a non-green level only comes from check
   a_level_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.health_level != LVL_GREEN
         |-> rsp_payload.status == STATUS_OK || rsp_payload.status == STATUS_NOTFOUND)
      else $error("health level with a register status");

endmodule

bind heartbeat_health_table_top hht_checker u_hht_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
